>>> rtl/core/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants shared by the sound header parser modules.
// ----------------------------------------------------------------------------
package shp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_VOC_HDR   = 4'd1,
        PH_VOC_BLK   = 4'd2,
        PH_VOC_TC    = 4'd3,
        PH_VOC_T9    = 4'd4,
        PH_VOC_SKIP  = 4'd5,
        PH_WAV_HDR   = 4'd6,
        PH_WAV_CHUNK = 4'd7,
        PH_WAV_FMT   = 4'd8,
        PH_WAV_SKIP  = 4'd9
    } shp_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1
    } shp_back_state_t;

    // one decided file, handed from the front to the back
    typedef struct packed {
        logic        status;
        logic        container;
        logic        need_div;
        logic [7:0]  tc;
        logic [31:0] rate;
        logic [7:0]  bits;
        logic [7:0]  channels;
        logic [31:0] offset;
        logic [31:0] length;
    } shp_req_t;

    localparam logic [7:0]  CHAR_UC_C    = 8'h43;
    localparam logic [7:0]  CHAR_LC_R    = 8'h72;
    localparam logic [7:0]  CHAR_UC_R    = 8'h52;
    localparam logic [31:0] VOC_MIN_SIZE = 32'h1A;
    localparam logic [15:0] VOC_MIN_BLK  = 16'h1A;
    localparam logic [31:0] VOC_OFS_LO   = 32'h14;
    localparam logic [31:0] VOC_OFS_HI   = 32'h15;
    localparam logic [31:0] VOC_WALK     = 32'h16;
    localparam logic [31:0] WAV_MIN_SIZE = 32'd44;
    localparam logic [31:0] TAG_FMT      = 32'h20746D66;
    localparam logic [31:0] TAG_DATA     = 32'h61746164;
    localparam logic [7:0]  BLK_END      = 8'd0;
    localparam logic [7:0]  BLK_SOUND    = 8'd1;
    localparam logic [7:0]  BLK_EXT      = 8'd9;
    localparam logic [31:0] RATE_DEFAULT = 32'd11025;
    localparam logic [15:0] FMT_PCM      = 16'd1;

    localparam logic [19:0] DIV_DIVIDEND = 20'd1000000;
    localparam int          DIV_STEPS    = 20;

    function automatic logic [7:0] wav_magic(input logic [3:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (idx)
            4'd0:    r = 8'h52;
            4'd1:    r = 8'h49;
            4'd2:    r = 8'h46;
            4'd3:    r = 8'h46;
            4'd8:    r = 8'h57;
            4'd9:    r = 8'h41;
            4'd10:   r = 8'h56;
            4'd11:   r = 8'h45;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/shp_front.sv
// ----------------------------------------------------------------------------
// shp_front
// Byte-wide parser: walks the VOC blocks or WAV chunks and posts one
// decision per file into the queue.
// ----------------------------------------------------------------------------
module shp_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_first_byte,
    input  logic [31:0]      s_file_size,
    input  logic             q_full,
    output logic             push,
    output shp_pkg::shp_req_t req
);
    import shp_pkg::*;

    shp_phase_t  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] tag_reg, tag_next;
    logic [7:0]  kind_reg, kind_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] bstart_reg, bstart_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  bits_reg, bits_next;
    logic [7:0]  ch_reg, ch_next;
    logic [31:0] size_reg, size_next;
    logic        fin_reg, fin_next;

    logic        accept;
    logic        concl, c_rej, c_wav, c_div;
    logic [31:0] c_off, c_len;
    logic [7:0]  c_tc, b;
    logic [31:0] pos, pos1, avail, len_v;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign b       = s_data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            idx_reg      <= '0;
            rem_reg      <= '0;
            tag_reg      <= '0;
            kind_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            bstart_reg   <= '0;
            rate_reg     <= RATE_DEFAULT;
            bits_reg     <= 8'd8;
            ch_reg       <= 8'd1;
            size_reg     <= '0;
            fin_reg      <= 1'b1;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            rem_reg      <= rem_next;
            tag_reg      <= tag_next;
            kind_reg     <= kind_next;
            fmt_seen_reg <= fmt_seen_next;
            bstart_reg   <= bstart_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            ch_reg       <= ch_next;
            size_reg     <= size_next;
            fin_reg      <= fin_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        tag_next      = tag_reg;
        kind_next     = kind_reg;
        fmt_seen_next = fmt_seen_reg;
        bstart_next   = bstart_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        ch_next       = ch_reg;
        size_next     = size_reg;
        fin_next      = fin_reg;
        concl = 1'b0;
        c_rej = 1'b0;
        c_wav = 1'b0;
        c_div = 1'b0;
        c_off = '0;
        c_len = '0;
        c_tc  = '0;
        pos   = pos_reg;
        pos1  = pos_reg + 32'd1;
        avail = size_reg - pos1;
        len_v = '0;
        push  = 1'b0;
        req   = '0;

        if (accept) begin
            if (s_first_byte) begin
                phase_next    = PH_IDLE;
                pos_next      = 32'd1;
                idx_next      = '0;
                rem_next      = '0;
                tag_next      = '0;
                kind_next     = '0;
                fmt_seen_next = 1'b0;
                bstart_next   = '0;
                rate_next     = RATE_DEFAULT;
                bits_next     = 8'd8;
                ch_next       = 8'd1;
                size_next     = s_file_size;
                fin_next      = 1'b0;
                c_wav         = (b != CHAR_UC_C);
                if (s_file_size == 32'd0 || (s_file_size >> OFFSET_BITS) != 32'd0) begin
                    concl = 1'b1;
                    c_rej = 1'b1;
                end else if (!c_wav) begin
                    if (s_file_size < VOC_MIN_SIZE) begin
                        concl = 1'b1;
                        c_rej = 1'b1;
                    end else begin
                        phase_next = PH_VOC_HDR;
                    end
                end else if (s_file_size < WAV_MIN_SIZE || b != CHAR_UC_R) begin
                    concl = 1'b1;
                    c_rej = 1'b1;
                end else begin
                    phase_next = PH_WAV_HDR;
                end
            end else if (!fin_reg) begin
                pos_next = pos1;
                c_wav    = (phase_reg >= PH_WAV_HDR);
                unique case (phase_reg)
                    PH_VOC_HDR: begin
                        if (pos == 32'd1 && b != CHAR_LC_R) begin
                            concl = 1'b1;
                            c_rej = 1'b1;
                        end else begin
                            if (pos == VOC_OFS_LO) bstart_next = {8'h00, b};
                            if (pos == VOC_OFS_HI) begin
                                bstart_next = {b, bstart_reg[7:0]};
                                if ({16'h0000, bstart_next} >= size_reg ||
                                    bstart_next < VOC_MIN_BLK) begin
                                    concl = 1'b1;
                                    c_rej = 1'b1;
                                end
                            end
                            if (pos >= VOC_WALK && pos1 == {16'h0000, bstart_reg}) begin
                                idx_next   = '0;
                                phase_next = PH_VOC_BLK;
                            end
                        end
                    end
                    PH_VOC_BLK: begin
                        idx_next = idx_reg + 4'd1;
                        case (idx_reg)
                            4'd0: begin
                                kind_next = b;
                                if (b == BLK_END) begin
                                    concl = 1'b1;
                                    c_rej = 1'b1;
                                end
                            end
                            4'd1:    rem_next = {24'h0, b};
                            4'd2:    rem_next = rem_reg | {16'h0, b, 8'h00};
                            default: len_v    = rem_reg | {8'h00, b, 16'h0};
                        endcase
                        if (idx_reg == 4'd3) begin
                            idx_next = '0;
                            rem_next = len_v;
                            if (len_v > avail) begin
                                concl = 1'b1;
                                c_rej = 1'b1;
                            end else if (kind_reg == BLK_SOUND && len_v >= 32'd2) begin
                                rem_next   = len_v - 32'd2;
                                phase_next = PH_VOC_TC;
                            end else if (kind_reg == BLK_EXT && len_v >= 32'd12) begin
                                rem_next   = len_v - 32'd12;
                                phase_next = PH_VOC_T9;
                            end else begin
                                phase_next = (len_v != 32'd0) ? PH_VOC_SKIP : PH_VOC_BLK;
                            end
                        end
                    end
                    PH_VOC_TC: begin
                        bits_next = 8'd8;
                        ch_next   = 8'd1;
                        concl     = 1'b1;
                        c_div     = 1'b1;
                        c_tc      = b;
                        c_off     = pos + 32'd2;
                        c_len     = rem_reg;
                    end
                    PH_VOC_T9: begin
                        idx_next = idx_reg + 4'd1;
                        case (idx_reg)
                            4'd0: rate_next = {24'h0, b};
                            4'd1: rate_next = rate_reg | {16'h0, b, 8'h00};
                            4'd2: rate_next = rate_reg | {8'h00, b, 16'h0};
                            4'd3: rate_next = rate_reg | {b, 24'h0};
                            4'd4: bits_next = b;
                            default: begin
                                ch_next = b;
                                concl   = 1'b1;
                                c_off   = pos + 32'd7;
                                c_len   = rem_reg;
                            end
                        endcase
                    end
                    PH_VOC_SKIP, PH_WAV_SKIP: begin
                        rem_next = rem_reg - 32'd1;
                        if (rem_next == 32'd0) begin
                            idx_next   = '0;
                            phase_next = c_wav ? PH_WAV_CHUNK : PH_VOC_BLK;
                        end
                    end
                    PH_WAV_HDR: begin
                        if (pos < 32'd12 && (pos < 32'd4 || pos >= 32'd8) &&
                            b != wav_magic(pos[3:0])) begin
                            concl = 1'b1;
                            c_rej = 1'b1;
                        end else if (pos >= 32'd11) begin
                            idx_next   = '0;
                            phase_next = PH_WAV_CHUNK;
                        end
                    end
                    PH_WAV_CHUNK: begin
                        idx_next = idx_reg + 4'd1;
                        case (idx_reg)
                            4'd0:    tag_next = {24'h0, b};
                            4'd1:    tag_next = tag_reg | {16'h0, b, 8'h00};
                            4'd2:    tag_next = tag_reg | {8'h00, b, 16'h0};
                            4'd3:    tag_next = tag_reg | {b, 24'h0};
                            4'd4:    rem_next = {24'h0, b};
                            4'd5:    rem_next = rem_reg | {16'h0, b, 8'h00};
                            4'd6:    rem_next = rem_reg | {8'h00, b, 16'h0};
                            default: len_v    = rem_reg | {b, 24'h0};
                        endcase
                        if (idx_reg == 4'd7) begin
                            idx_next = '0;
                            rem_next = len_v;
                            if (len_v > avail) begin
                                concl = 1'b1;
                                c_rej = 1'b1;
                            end else if (tag_reg == TAG_FMT && len_v >= 32'd16) begin
                                fmt_seen_next = 1'b1;
                                rem_next      = len_v - 32'd16 + {31'h0, len_v[0]};
                                phase_next    = PH_WAV_FMT;
                            end else if (tag_reg == TAG_DATA) begin
                                concl = 1'b1;
                                c_rej = !fmt_seen_reg;
                                c_off = pos1;
                                c_len = len_v;
                            end else begin
                                rem_next   = len_v + {31'h0, len_v[0]};
                                phase_next = (rem_next != 32'd0) ? PH_WAV_SKIP : PH_WAV_CHUNK;
                            end
                        end
                    end
                    PH_WAV_FMT: begin
                        idx_next = idx_reg + 4'd1;
                        case (idx_reg)
                            4'd0: kind_next = b;
                            4'd1: begin
                                if ({b, kind_reg} != FMT_PCM) begin
                                    concl = 1'b1;
                                    c_rej = 1'b1;
                                end
                            end
                            4'd2:  ch_next   = b;
                            4'd4:  rate_next = {24'h0, b};
                            4'd5:  rate_next = rate_reg | {16'h0, b, 8'h00};
                            4'd6:  rate_next = rate_reg | {8'h00, b, 16'h0};
                            4'd7:  rate_next = rate_reg | {b, 24'h0};
                            4'd14: bits_next = b;
                            default: ;
                        endcase
                        if (idx_reg == 4'd15) begin
                            idx_next   = '0;
                            phase_next = (rem_reg != 32'd0) ? PH_WAV_SKIP : PH_WAV_CHUNK;
                        end
                    end
                    default: begin
                        concl = 1'b1;
                        c_rej = 1'b1;
                    end
                endcase
                // file ran out with nothing decided
                if (!concl && pos1 >= size_reg) begin
                    concl = 1'b1;
                    c_rej = 1'b1;
                end
            end

            if (concl) begin
                fin_next       = 1'b1;
                phase_next     = PH_IDLE;
                push           = 1'b1;
                req.status     = c_rej;
                req.container  = c_wav;
                req.need_div   = c_div && !c_rej;
                req.tc         = c_tc;
                req.rate       = c_rej ? 32'd0 : rate_next;
                req.bits       = c_rej ? 8'd0 : bits_next;
                req.channels   = c_rej ? 8'd0 : ch_next;
                req.offset     = c_rej ? 32'd0 : c_off;
                req.length     = c_rej ? 32'd0 : c_len;
            end
        end
    end

endmodule

>>> rtl/core/shp_queue.sv
// ----------------------------------------------------------------------------
// shp_queue
// Two-entry queue of decided files between the parser and the result stage.
// ----------------------------------------------------------------------------
module shp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  shp_pkg::shp_req_t req_in,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output shp_pkg::shp_req_t req_out
);
    import shp_pkg::*;

    shp_req_t    mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign req_out = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= req_in;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push while queue full");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/shp_back.sv
// ----------------------------------------------------------------------------
// shp_back
// Result stage: finishes the VOC rate division and holds the result register.
// ----------------------------------------------------------------------------
module shp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  shp_pkg::shp_req_t q_req,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic              m_container,
    output logic [31:0]       m_sample_rate,
    output logic [7:0]        m_bits_per_sample,
    output logic [7:0]        m_channels,
    output logic [31:0]       m_data_offset,
    output logic [31:0]       m_data_length
);
    import shp_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    shp_back_state_t state_reg, state_next;
    shp_req_t        ent_reg, ent_next;
    shp_req_t        out_reg, out_next;
    logic            m_valid_reg, m_valid_next;
    logic [8:0]      div_reg, div_next;
    logic [8:0]      rem_reg, rem_next;
    logic [19:0]     dvd_reg, dvd_next;
    logic [19:0]     quo_reg, quo_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_free;
    logic [9:0]      trial;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        out_reg <= out_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    always_comb begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        pop          = 1'b0;
        trial        = {rem_reg, dvd_reg[19]};

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    pop = 1'b1;
                    if (q_req.need_div) begin
                        ent_next   = q_req;
                        div_next   = 9'd256 - {1'b0, q_req.tc};
                        rem_next   = '0;
                        dvd_next   = DIV_DIVIDEND;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = BK_DIV;
                    end else begin
                        out_next     = q_req;
                        m_valid_next = 1'b1;
                    end
                end
            end
            BK_DIV: begin
                if (cnt_reg != CW'(DIV_STEPS)) begin
                    // restoring division, one quotient bit a cycle
                    if (trial >= {1'b0, div_reg}) begin
                        rem_next = 9'(trial - {1'b0, div_reg});
                        quo_next = {quo_reg[18:0], 1'b1};
                    end else begin
                        rem_next = trial[8:0];
                        quo_next = {quo_reg[18:0], 1'b0};
                    end
                    dvd_next = {dvd_reg[18:0], 1'b0};
                    cnt_next = cnt_reg + CW'(1);
                end else if (out_free) begin
                    out_next      = ent_reg;
                    out_next.rate = {12'h000, quo_reg};
                    m_valid_next  = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_container       = out_reg.container;
    assign m_sample_rate     = out_reg.rate;
    assign m_bits_per_sample = out_reg.bits;
    assign m_channels        = out_reg.channels;
    assign m_data_offset     = out_reg.offset;
    assign m_data_length     = out_reg.length;

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV && state_next == BK_IDLE) |-> (cnt_reg == CW'(DIV_STEPS)))
        else $error("division left before all steps");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == BK_IDLE && out_free))
        else $error("queue popped while result stage busy");

endmodule

>>> rtl/core/sound_header_parser.sv
// path: a decision is queued, then moved into the result register that drives m_valid
// once it is free; a VOC sound block (type 1) first runs through the 20-step rate divider
// throughput: one byte per cycle; the byte port stalls only when the two-entry decision
// queue is full, which the divider can cause for back-to-back short files
// reset: aresetn synchronous, active low; afterwards bytes are ignored until first_byte
// ----------------------------------------------------------------------------
// sound_header_parser
// Streaming VOC / RIFF WAVE header parser giving format, data offset and length.
// ----------------------------------------------------------------------------
module sound_header_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic [31:0] s_file_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_container,
    output logic [31:0] m_sample_rate,
    output logic [7:0]  m_bits_per_sample,
    output logic [7:0]  m_channels,
    output logic [31:0] m_data_offset,
    output logic [31:0] m_data_length
);
    import shp_pkg::*;

    logic     push, q_full, q_empty, pop;
    shp_req_t req_in, req_out;

    shp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .s_file_size  (s_file_size),
        .q_full       (q_full),
        .push         (push),
        .req          (req_in)
    );

    shp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .req_in  (req_in),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .req_out (req_out)
    );

    shp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_empty           (q_empty),
        .q_req             (req_out),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_container       (m_container),
        .m_sample_rate     (m_sample_rate),
        .m_bits_per_sample (m_bits_per_sample),
        .m_channels        (m_channels),
        .m_data_offset     (m_data_offset),
        .m_data_length     (m_data_length)
    );

endmodule

>>> tb/sv/tb_sound_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sound_header_parser
// Streams VOC and RIFF WAVE files into the parser byte by byte and checks each
// decision against a byte-accurate behavioural parser kept in the testbench.
// ----------------------------------------------------------------------------
module tb_sound_header_parser;
    import shp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic [31:0] s_file_size;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic        m_container;
    logic [31:0] m_sample_rate;
    logic [7:0]  m_bits_per_sample;
    logic [7:0]  m_channels;
    logic [31:0] m_data_offset;
    logic [31:0] m_data_length;

    sound_header_parser uut (.*);

    typedef struct packed {
        logic        status;
        logic        container;
        logic [31:0] rate;
        logic [7:0]  bits;
        logic [7:0]  channels;
        logic [31:0] offset;
        logic [31:0] length;
    } decision_t;

    decision_t decisions_due[$];
    int        mismatches;
    int        decisions_seen;
    int        bytes_sent;
    int        files_sent;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold;
    int        quiet_cycles;
    bit        timed_out;

    // predictor state
    logic [31:0] p_pos;
    shp_phase_t  p_phase;
    logic [31:0] p_shift;
    logic [31:0] p_remain;
    logic [31:0] p_tag;
    logic [7:0]  p_kind;
    logic        p_fmt_seen;
    logic [15:0] p_blk_start;
    logic [31:0] p_rate;
    logic [7:0]  p_bits;
    logic [7:0]  p_chans;
    logic [31:0] p_size;
    logic        p_done;

    logic [7:0] file_buf[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic decide(input logic rej, input logic wav, input logic [31:0] ofs,
                          input logic [31:0] len);
        decision_t d;
        d.status    = rej;
        d.container = wav;
        d.rate      = rej ? 32'd0 : p_rate;
        d.bits      = rej ? 8'd0 : p_bits;
        d.channels  = rej ? 8'd0 : p_chans;
        d.offset    = rej ? 32'd0 : ofs;
        d.length    = rej ? 32'd0 : len;
        decisions_due.push_back(d);
        p_done  = 1'b1;
        p_phase = PH_IDLE;
    endtask

    function automatic logic [7:0] riff_magic(input logic [31:0] i);
        case (i)
            0: return CHAR_UC_R;
            1: return 8'h49;
            2, 3: return 8'h46;
            8: return 8'h57;
            9: return 8'h41;
            10: return 8'h56;
            11: return 8'h45;
            default: return 8'h00;
        endcase
    endfunction

    task automatic predictor_reset();
        p_pos = 0; p_phase = PH_IDLE; p_shift = 0; p_remain = 0; p_tag = 0;
        p_kind = 0; p_fmt_seen = 0; p_blk_start = 0; p_rate = RATE_DEFAULT;
        p_bits = 8; p_chans = 1; p_size = 0; p_done = 1;
    endtask

    // advances the parser model by one byte and queues any decision it makes
    task automatic parse_byte(input logic [7:0] b, input logic first, input logic [31:0] fsz);
        logic [31:0] pos, idx, len, avail;
        logic        wav;
        if (first) begin
            predictor_reset();
            p_done = 0; p_size = fsz; p_pos = 1;
            wav = (b != CHAR_UC_C);
            if (fsz == 0) begin
                decide(1, wav, 0, 0);
            end else if (!wav) begin
                if (fsz < VOC_MIN_SIZE) decide(1, 0, 0, 0);
                else p_phase = PH_VOC_HDR;
            end else begin
                if (fsz < WAV_MIN_SIZE || b != CHAR_UC_R) decide(1, 1, 0, 0);
                else p_phase = PH_WAV_HDR;
            end
            return;
        end
        if (p_done) return;
        pos = p_pos;
        p_pos = pos + 1;
        wav = (p_phase >= PH_WAV_HDR);
        idx = p_shift;
        case (p_phase)
            PH_VOC_HDR: begin
                if (pos == 1 && b != CHAR_LC_R) begin decide(1, 0, 0, 0); return; end
                if (pos == VOC_OFS_LO) p_blk_start = {8'd0, b};
                if (pos == VOC_OFS_HI) begin
                    p_blk_start = p_blk_start | {b, 8'd0};
                    if (p_blk_start >= p_size || p_blk_start < VOC_MIN_BLK) begin
                        decide(1, 0, 0, 0); return;
                    end
                end
                if (pos >= VOC_WALK && pos + 1 == {16'd0, p_blk_start}) begin
                    p_shift = 0; p_phase = PH_VOC_BLK;
                end
            end
            PH_VOC_BLK: begin
                if (idx == 0) begin
                    p_kind = b;
                    if (b == BLK_END) begin decide(1, 0, 0, 0); return; end
                end else if (idx == 1) p_remain = b;
                else p_remain |= {24'd0, b} << (8 * ((idx - 1) & 3));
                p_shift = idx + 1;
                if (idx >= 3) begin
                    len = p_remain; avail = p_size - (pos + 1); p_shift = 0;
                    if (len > avail) begin decide(1, 0, 0, 0); return; end
                    if (p_kind == BLK_SOUND && len >= 2) begin
                        p_remain = len - 2; p_phase = PH_VOC_TC;
                    end else if (p_kind == BLK_EXT && len >= 12) begin
                        p_remain = len - 12; p_phase = PH_VOC_T9;
                    end else p_phase = (len != 0) ? PH_VOC_SKIP : PH_VOC_BLK;
                end
            end
            PH_VOC_TC: begin
                p_rate = 32'd1000000 / (32'd256 - {24'd0, b});
                p_bits = 8; p_chans = 1;
                decide(0, 0, pos + 2, p_remain); return;
            end
            PH_VOC_T9: begin
                if (idx == 0) p_rate = b;
                else if (idx < 4) p_rate |= {24'd0, b} << (8 * idx);
                else if (idx == 4) p_bits = b;
                else begin
                    p_chans = b; decide(0, 0, pos + 7, p_remain); return;
                end
                p_shift = idx + 1;
            end
            PH_VOC_SKIP, PH_WAV_SKIP: begin
                p_remain = p_remain - 1;
                if (p_remain == 0) begin
                    p_shift = 0; p_phase = wav ? PH_WAV_CHUNK : PH_VOC_BLK;
                end
            end
            PH_WAV_HDR: begin
                if (pos < 12 && (pos < 4 || pos >= 8) && b != riff_magic(pos)) begin
                    decide(1, 1, 0, 0); return;
                end
                if (pos >= 11) begin p_shift = 0; p_phase = PH_WAV_CHUNK; end
            end
            PH_WAV_CHUNK: begin
                if (idx == 0) p_tag = b;
                else if (idx < 4) p_tag |= {24'd0, b} << (8 * idx);
                else if (idx == 4) p_remain = b;
                else p_remain |= {24'd0, b} << (8 * ((idx - 4) & 3));
                p_shift = idx + 1;
                if (idx >= 7) begin
                    len = p_remain; avail = p_size - (pos + 1); p_shift = 0;
                    if (len > avail) begin decide(1, 1, 0, 0); return; end
                    if (p_tag == TAG_FMT && len >= 16) begin
                        p_fmt_seen = 1;
                        p_remain = len - 16 + (len & 1);
                        p_phase = PH_WAV_FMT;
                    end else if (p_tag == TAG_DATA) begin
                        if (!p_fmt_seen) decide(1, 1, 0, 0);
                        else decide(0, 1, pos + 1, len);
                        return;
                    end else begin
                        p_remain = len + (len & 1);
                        p_phase = (p_remain != 0) ? PH_WAV_SKIP : PH_WAV_CHUNK;
                    end
                end
            end
            PH_WAV_FMT: begin
                if (idx == 0) p_kind = b;
                else if (idx == 1) begin
                    if ({b, p_kind} != FMT_PCM) begin decide(1, 1, 0, 0); return; end
                end else if (idx == 2) p_chans = b;
                else if (idx == 4) p_rate = b;
                else if (idx >= 5 && idx <= 7) p_rate |= {24'd0, b} << (8 * (idx - 4));
                else if (idx == 14) p_bits = b;
                p_shift = idx + 1;
                if (idx >= 15) begin
                    p_shift = 0;
                    p_phase = (p_remain != 0) ? PH_WAV_SKIP : PH_WAV_CHUNK;
                end
            end
            default: begin decide(1, wav, 0, 0); return; end
        endcase
        if (pos + 1 >= p_size) decide(1, wav, 0, 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on decision %0d: %s got %0h want %0h",
                 decisions_seen, what, got, want);
        mismatches++;
    endtask

    // one byte transfer; sender idling is applied before the byte is offered
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] fsz);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1; s_data_byte = b; s_first_byte = first; s_file_size = fsz;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, first, fsz);
        bytes_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // streams the buffered file; len_bytes bounds how much of it is sent
    task automatic send_file(input logic [31:0] fsz, input int len_bytes);
        for (int i = 0; i < len_bytes && i < file_buf.size(); i++)
            send_byte(file_buf[i], i == 0, fsz);
        files_sent++;
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_buf.push_back(v[8 * i +: 8]);
    endtask

    // valid VOC file, optionally mutated by the caller afterwards
    task automatic build_voc(input int blk_ofs, input bit ext, input int pre_skip);
        file_buf.delete();
        file_buf.push_back(CHAR_UC_C);
        file_buf.push_back(CHAR_LC_R);
        while (file_buf.size() < 20) file_buf.push_back($urandom);
        push_le(blk_ofs, 2);
        while (file_buf.size() < blk_ofs) file_buf.push_back($urandom);
        if (pre_skip > 0) begin
            file_buf.push_back(8'd2 + $urandom_range(5)); push_le(pre_skip, 3);
            repeat (pre_skip) file_buf.push_back($urandom);
        end
        if (ext) begin
            file_buf.push_back(BLK_EXT); push_le(12 + $urandom_range(6), 3);
            push_le($urandom, 4); file_buf.push_back($urandom); file_buf.push_back($urandom);
        end else begin
            file_buf.push_back(BLK_SOUND); push_le(2 + $urandom_range(8), 3);
            file_buf.push_back($urandom);
        end
        repeat (2 + $urandom_range(20)) file_buf.push_back($urandom);
    endtask

    // valid WAV file with an optional junk chunk and a fmt chunk of the given, possibly odd, size
    task automatic build_wav(input int junk, input int fmt_len);
        file_buf.delete();
        push_le(32'h46464952, 4); push_le($urandom, 4); push_le(32'h45564157, 4);
        if (junk >= 0) begin
            push_le(32'h4B4E554A, 4); push_le(junk, 4);
            repeat (junk + (junk & 1)) file_buf.push_back($urandom);
        end
        push_le(TAG_FMT, 4); push_le(fmt_len, 4); push_le(FMT_PCM, 2);
        file_buf.push_back($urandom); file_buf.push_back($urandom);
        push_le($urandom, 4); push_le($urandom, 4); push_le($urandom, 2);
        file_buf.push_back($urandom); file_buf.push_back($urandom);
        repeat (fmt_len - 16 + (fmt_len & 1)) file_buf.push_back($urandom);
        push_le(TAG_DATA, 4); push_le($urandom_range(30), 4);
        repeat (4) file_buf.push_back($urandom);
    endtask

    task automatic wait_drained();
        while (decisions_due.size() != 0 && !timed_out) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic test_directed();
        // empty file, wrong magics, tiny sizes, bytes with no file open
        file_buf = '{CHAR_UC_C}; send_file(0, 1);
        file_buf = '{8'hFF}; send_file(32'hFFFF_FFFF, 1);
        file_buf = '{CHAR_UC_C, 8'h00}; send_file(25, 2);
        file_buf = '{CHAR_UC_R}; send_file(43, 1);
        send_byte(8'hAA, 0, 100);
        send_byte(8'h55, 0, 100);
        build_voc(26, 0, 0); file_buf[1] = 8'h00; send_file(file_buf.size(), 3);
        // block start too low, and beyond the file
        build_voc(26, 0, 0); file_buf[20] = 8'h19; send_file(file_buf.size(), 30);
        build_voc(26, 0, 0); send_file(26, 40);
        // sound block with time constants at both ends, extended block
        build_voc(26, 0, 0); file_buf[30] = 8'h00; send_file(file_buf.size(), 99);
        build_voc(26, 0, 0); file_buf[30] = 8'hFF; send_file(file_buf.size(), 99);
        build_voc(40, 1, 3); send_file(file_buf.size(), 99);
        // terminator block, oversized block
        build_voc(26, 0, 0); file_buf[26] = BLK_END; send_file(file_buf.size(), 99);
        build_voc(26, 0, 0); file_buf[29] = 8'hFF; send_file(file_buf.size(), 99);
        // file runs out mid-header
        build_voc(26, 0, 4); send_file(28, 99);
        // wav: good, odd junk with odd fmt, long fmt, non-PCM, data before fmt, bad WAVE tag
        build_wav(-1, 16); send_file(file_buf.size(), 99);
        build_wav(3, 17); send_file(file_buf.size(), 99);
        build_wav(0, 18); send_file(file_buf.size(), 99);
        build_wav(-1, 16); file_buf[20] = 8'h03; send_file(file_buf.size(), 99);
        build_wav(-1, 16);
        file_buf[12] = 8'h64; file_buf[13] = 8'h61; file_buf[14] = 8'h74; file_buf[15] = 8'h61;
        send_file(file_buf.size(), 99);
        build_wav(-1, 16); file_buf[9] = 8'h00; send_file(file_buf.size(), 99);
        // restart mid-file abandons it
        build_wav(-1, 16); send_file(file_buf.size(), 20);
        wait_drained();
    endtask

    task automatic test_random(input int target);
        int  kind, len, k;
        while (bytes_sent < target && !timed_out) begin
            kind = $urandom_range(9);
            if (kind < 4) build_voc(26 + $urandom_range(20), $urandom_range(1),
                                    $urandom_range(1) ? 0 : $urandom_range(1, 6));
            else if (kind < 8) build_wav($urandom_range(1) ? -1 : $urandom_range(7),
                                         16 + $urandom_range(3));
            else begin
                file_buf.delete();
                file_buf.push_back($urandom_range(1) ? CHAR_UC_C : CHAR_UC_R);
                repeat ($urandom_range(60)) file_buf.push_back($urandom);
            end
            // occasional corruption or truncation
            if ($urandom_range(4) == 0) begin
                k = $urandom_range(file_buf.size() - 1);
                file_buf[k] = $urandom;
            end
            len = ($urandom_range(5) == 0) ? $urandom_range(1, file_buf.size())
                                           : file_buf.size();
            send_file(($urandom_range(7) == 0) ? $urandom : file_buf.size(), len);
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while short files queue up behind the divider
        recv_hold = 300;
        repeat (12) begin
            file_buf = '{CHAR_UC_C}; send_file(0, 1);
            build_voc(26, 0, 0); send_file(file_buf.size(), 99);
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge aclk) begin
        decision_t d;
        if (aresetn && m_valid && m_ready) begin
            decisions_seen++;
            if (decisions_due.size() == 0) begin
                $display("unexpected decision %0d", decisions_seen);
                mismatches++;
            end else begin
                d = decisions_due.pop_front();
                if (m_status != d.status) report_mismatch("status", m_status, d.status);
                if (m_container != d.container)
                    report_mismatch("container", m_container, d.container);
                if (m_sample_rate != d.rate) report_mismatch("rate", m_sample_rate, d.rate);
                if (m_bits_per_sample != d.bits)
                    report_mismatch("bits", m_bits_per_sample, d.bits);
                if (m_channels != d.channels) report_mismatch("channels", m_channels, d.channels);
                if (m_data_offset != d.offset) report_mismatch("offset", m_data_offset, d.offset);
                if (m_data_length != d.length) report_mismatch("length", m_data_length, d.length);
            end
        end
    end

    // receiver ready, with a long hold-off when requested
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || recv_hold > 0) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        s_valid = 0; s_data_byte = 0; s_first_byte = 0; s_file_size = 0;
        m_ready = 0; aresetn = 0; recv_hold = 0; quiet_cycles = 0; timed_out = 0;
        mismatches = 0; decisions_seen = 0; bytes_sent = 0; files_sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        predictor_reset();
        repeat (6) @(negedge aclk);
        aresetn = 1;
        test_directed();
        send_idle_pct = 36; recv_idle_pct = 47;
        test_random(700);
        wait_drained();
        send_idle_pct = 47; recv_idle_pct = 36;
        test_random(1300);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(1900);
        wait_drained();
        $display("covered %0d files in %0d bytes, %0d decisions checked",
                 files_sent, bytes_sent, decisions_seen);
        if (mismatches == 0 && decisions_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d decisions missing", mismatches, decisions_due.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
